// ----- rtl/svss_pkg.sv -----
// ----------------------------------------------------------------------------
// svss_pkg
// Shared types and codes for the sparse voxel section store.
// ----------------------------------------------------------------------------
package svss_pkg;

  localparam int CoordW = 24;
  localparam int DataW  = 32;
  localparam int StatW  = 3;

  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  localparam logic [StatW-1:0] StatHit       = 3'd0;
  localparam logic [StatW-1:0] StatMiss      = 3'd1;
  localparam logic [StatW-1:0] StatUnchanged = 3'd2;
  localparam logic [StatW-1:0] StatAlloc     = 3'd3;
  localparam logic [StatW-1:0] StatFreed     = 3'd4;
  localparam logic [StatW-1:0] StatFull      = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } key_t;

endpackage

// ----- rtl/svss_coord_split.sv -----
// ----------------------------------------------------------------------------
// svss_coord_split
// Floor division of one signed coordinate by the section edge, in two
// registered steps: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module svss_coord_split #(
  parameter int SECTION_EDGE = 16
) (
  input  logic                                  clk_i,
  input  logic                                  mul_en_i,
  input  logic                                  fix_en_i,
  input  logic signed [svss_pkg::CoordW-1:0]    v_i,
  output logic signed [svss_pkg::CoordW-1:0]    q_o,
  output logic [$clog2(SECTION_EDGE)-1:0]       r_o
);
  import svss_pkg::*;

  localparam int EW = $clog2(SECTION_EDGE);
  localparam int UW = CoordW + EW + 1;
  localparam int PW = UW + 32;
  localparam logic [32:0] Recip = 33'((64'h1_0000_0000) / SECTION_EDGE);
  localparam logic [UW-1:0] Bias = UW'(SECTION_EDGE * (2 ** (CoordW - 1)));
  localparam logic [UW-1:0] Half = UW'(2 ** (CoordW - 1));
  localparam logic [UW-1:0] Edge = UW'(SECTION_EDGE);

  logic [UW-1:0] u;
  logic [PW-1:0] prod_d;
  logic [PW-1:0] prod_q;
  logic [UW-1:0] u_q;
  logic [UW-1:0] q0;
  logic [UW-1:0] r0;
  logic          ge;
  logic [UW-1:0] q1;
  logic [UW-1:0] r1;
  logic signed [CoordW-1:0] q_q;
  logic [EW-1:0] r_q;

  assign u      = UW'(v_i) + Bias;
  assign prod_d = PW'(u) * PW'(Recip[31:0]);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
      u_q    <= u;
    end
  end

  // estimate is exact or one low
  assign q0 = prod_q[PW-1:32];
  assign r0 = u_q - UW'(q0 * Edge);
  assign ge = (r0 >= Edge);
  assign q1 = ge ? q0 + UW'(1) : q0;
  assign r1 = ge ? r0 - Edge : r0;

  always_ff @(posedge clk_i) begin
    if (fix_en_i) begin
      q_q <= CoordW'(q1 - Half);
      r_q <= EW'(r1);
    end
  end

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

// ----- rtl/sparse_voxel_section_store_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_voxel_section_store_unit
// Sparse voxel store: sections matched by key, cells in one voxel memory.
// ----------------------------------------------------------------------------
// After an item is accepted it passes through floor division (StDiv, StSplit),
// key match and memory read issue (StMatch) and the read-modify-write of the
// voxel memory and slot counters (StWb), in which the result is registered.
// s_axis_tready is high only in the idle state, so the next item is accepted
// in the cycle after the result is registered at the earliest: no new item is
// taken before the last one's result is registered. A result still waiting on
// m_axis_tready holds the write-back cycle. After reset the voxel memory is
// cleared one entry per cycle, all MAX_SECTIONS*SECTION_EDGE^3 entries, and no
// item is accepted until that pass ends.
module sparse_voxel_section_store_unit #(
  parameter int SECTION_EDGE = 16,
  parameter int MAX_SECTIONS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // pos_x, pos_y, pos_z, new_block_id, new_color, mark_dirty, zero pad
  input  logic [143:0]  s_axis_tdata,
  // kind
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // block_id_out, color_out
  output logic [63:0]   m_axis_tdata,
  // status
  output logic [2:0]    m_axis_tuser
);
  import svss_pkg::*;

  localparam int EW       = $clog2(SECTION_EDGE);
  localparam int CellsPer = SECTION_EDGE * SECTION_EDGE * SECTION_EDGE;
  localparam int Depth    = MAX_SECTIONS * CellsPer;
  localparam int AW       = $clog2(Depth);
  localparam int SW       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CntW     = $clog2(CellsPer + 1);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDiv   = 6'b000010,
    StSplit = 6'b000100,
    StMatch = 6'b001000,
    StWb    = 6'b010000,
    StClear = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic                     kind_q, mark_q;
  logic signed [CoordW-1:0] px_q, py_q, pz_q;
  logic [DataW-1:0]         nid_q, ncol_q;

  key_t          key;
  logic [EW-1:0] lx, ly, lz;

  key_t                  slot_key_q [MAX_SECTIONS];
  logic [MAX_SECTIONS-1:0] slot_valid_q;
  logic [CntW-1:0]       cnt_q   [MAX_SECTIONS];
  logic [DataW-1:0]      ver_q   [MAX_SECTIONS];
  logic [MAX_SECTIONS-1:0] dirty_q;

  logic [2*DataW-1:0] mem_q [Depth];
  logic [2*DataW-1:0] rd_q;
  logic [2*DataW-1:0] wdata;
  logic               mem_we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      addr_d, addr_q;
  logic [AW-1:0]      clr_q;

  logic          hit, free_ok, hit_q, free_ok_q;
  logic [SW-1:0] hit_idx, free_idx, slot_sel, slot_q;

  logic          out_valid_q;
  logic [63:0]   out_data_q;
  logic [2:0]    out_stat_q;

  logic             go;
  logic [DataW-1:0] old_id, old_col;
  logic [CntW-1:0]  cnt_base, cnt_new;
  logic [DataW-1:0] ver_base;
  logic             do_write, do_alloc, do_free;
  logic [2:0]       stat;
  logic [63:0]      out_data;

  assign s_axis_tready = (state_q == StIdle);

  svss_coord_split #(.SECTION_EDGE(SECTION_EDGE)) u_split_x (
    .clk_i, .mul_en_i(state_q == StDiv), .fix_en_i(state_q == StSplit),
    .v_i(px_q), .q_o(key.x), .r_o(lx)
  );
  svss_coord_split #(.SECTION_EDGE(SECTION_EDGE)) u_split_y (
    .clk_i, .mul_en_i(state_q == StDiv), .fix_en_i(state_q == StSplit),
    .v_i(py_q), .q_o(key.y), .r_o(ly)
  );
  svss_coord_split #(.SECTION_EDGE(SECTION_EDGE)) u_split_z (
    .clk_i, .mul_en_i(state_q == StDiv), .fix_en_i(state_q == StSplit),
    .v_i(pz_q), .q_o(key.z), .r_o(lz)
  );

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      px_q   <= s_axis_tdata[23:0];
      py_q   <= s_axis_tdata[47:24];
      pz_q   <= s_axis_tdata[71:48];
      nid_q  <= s_axis_tdata[103:72];
      ncol_q <= s_axis_tdata[135:104];
      mark_q <= s_axis_tdata[136];
    end
  end

  // associative match and lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int s = MAX_SECTIONS - 1; s >= 0; s--) begin
      if (slot_valid_q[s] && slot_key_q[s] == key) begin
        hit     = 1'b1;
        hit_idx = SW'(s);
      end
      if (!slot_valid_q[s]) begin
        free_ok  = 1'b1;
        free_idx = SW'(s);
      end
    end
    slot_sel = hit ? hit_idx : free_idx;
    addr_d   = AW'(int'(slot_sel) * CellsPer + int'(lx) + int'(ly) * SECTION_EDGE +
                   int'(lz) * SECTION_EDGE * SECTION_EDGE);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StMatch) begin
      hit_q     <= hit;
      free_ok_q <= free_ok;
      slot_q    <= slot_sel;
      addr_q    <= addr_d;
    end
  end

  // voxel memory: {color, id}
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    if (state_q == StMatch) rd_q <= mem_q[addr_d];
  end

  assign old_id  = rd_q[DataW-1:0];
  assign old_col = rd_q[2*DataW-1:DataW];
  assign go      = (state_q == StWb) && (!out_valid_q || m_axis_tready);

  always_comb begin
    cnt_base = hit_q ? cnt_q[slot_q] : '0;
    ver_base = hit_q ? ver_q[slot_q] : '0;
    cnt_new  = cnt_base;
    do_write = 1'b0;
    do_alloc = 1'b0;
    do_free  = 1'b0;
    stat     = StatMiss;
    out_data = '0;
    if (!hit_q && (kind_q == KindRead || nid_q == '0)) begin
      stat = StatMiss;
    end else if (!hit_q && !free_ok_q) begin
      stat = StatFull;
    end else begin
      out_data = {old_col, old_id};
      do_alloc = !hit_q;
      if (kind_q == KindRead) begin
        stat = StatHit;
      end else if (old_id == nid_q && old_col == ncol_q) begin
        stat = StatUnchanged;
      end else begin
        do_write = 1'b1;
        stat     = hit_q ? StatHit : StatAlloc;
        if (old_id == '0 && nid_q != '0) begin
          cnt_new = cnt_base + CntW'(1);
        end else if (old_id != '0 && nid_q == '0 && cnt_base != '0) begin
          cnt_new = cnt_base - CntW'(1);
        end
        if (cnt_new == '0) begin
          do_free = 1'b1;
          stat    = StatFreed;
        end
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = addr_q;
    wdata  = {(nid_q == '0) ? {DataW{1'b0}} : ncol_q, nid_q};
    if (state_q == StClear) begin
      mem_we = 1'b1;
      waddr  = clr_q;
      wdata  = '0;
    end else if (go && do_write) begin
      mem_we = 1'b1;
    end
  end

  // an allocation always comes with a write of a non-air block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      dirty_q      <= '0;
      for (int s = 0; s < MAX_SECTIONS; s++) begin
        cnt_q[s] <= '0;
        ver_q[s] <= '0;
      end
    end else if (go && do_write) begin
      slot_valid_q[slot_q] <= !do_free;
      cnt_q[slot_q]        <= cnt_new;
      if (mark_q) begin
        ver_q[slot_q] <= ver_base + DataW'(1);
      end else if (do_alloc) begin
        ver_q[slot_q] <= '0;
      end
      if (do_free) begin
        dirty_q[slot_q] <= 1'b0;
      end else if (mark_q) begin
        dirty_q[slot_q] <= 1'b1;
      end else if (do_alloc) begin
        dirty_q[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && do_alloc) slot_key_q[slot_q] <= key;
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_data_q <= out_data;
      out_stat_q <= stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + AW'(1);
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (s_axis_tvalid) state_d = StDiv;
      StDiv:   state_d = StSplit;
      StSplit: state_d = StMatch;
      StMatch: state_d = StWb;
      StWb:    if (go) state_d = StIdle;
      StClear: if (clr_q == AW'(Depth - 1)) state_d = StIdle;
      default: state_d = StClear;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

// ----- verif/svss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svss_checker
// Watches both streams of the voxel store, keeps its own copy of the section
// table and voxel cells, predicts each result and compares the whole of it.
// ----------------------------------------------------------------------------
module svss_checker #(
  parameter int SECTION_EDGE = 16,
  parameter int MAX_SECTIONS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  output int           errors_o,
  output int           pending_o,
  output int           results_o
);
  import svss_pkg::*;

  localparam int Cells = SECTION_EDGE * SECTION_EDGE * SECTION_EDGE;

  typedef struct packed {
    logic [DataW-1:0] id;
    logic [DataW-1:0] color;
    logic [StatW-1:0] status;
  } voxel_result_t;

  voxel_result_t result_q[$];
  key_t          sec_key[MAX_SECTIONS];
  bit            sec_valid[MAX_SECTIONS];
  int unsigned   sec_count[MAX_SECTIONS];
  logic [31:0]   sec_version[MAX_SECTIONS];
  bit            sec_dirty[MAX_SECTIONS];
  logic [31:0]   cell_id[int];
  logic [31:0]   cell_color[int];

  function automatic void split(input logic signed [CoordW-1:0] v,
                                output logic signed [CoordW-1:0] q, output int r);
    int iv;
    int iq;
    iv = v;
    iq = (iv >= 0) ? iv / SECTION_EDGE : -((-iv + SECTION_EDGE - 1) / SECTION_EDGE);
    q = iq;
    r = iv - iq * SECTION_EDGE;
  endfunction

  function automatic voxel_result_t access_voxel(input logic kind,
                                                 input logic [143:0] d);
    voxel_result_t res;
    key_t k;
    int lx, ly, lz, s, idx;
    logic [31:0] nid, ncol, oid, ocol;
    logic mark;
    logic signed [CoordW-1:0] qx, qy, qz;
    split(d[23:0], qx, lx);
    split(d[47:24], qy, ly);
    split(d[71:48], qz, lz);
    k.x = qx; k.y = qy; k.z = qz;
    nid = d[103:72];
    ncol = d[135:104];
    mark = d[136];
    res = '{id: '0, color: '0, status: StatMiss};
    s = -1;
    for (int i = 0; i < MAX_SECTIONS; i++)
      if (s < 0 && sec_valid[i] && sec_key[i] == k) s = i;
    if (s < 0) begin
      if (kind == KindRead || nid == 0) return res;
      for (int i = MAX_SECTIONS - 1; i >= 0; i--)
        if (!sec_valid[i]) s = i;
      if (s < 0) begin
        res.status = StatFull;
        return res;
      end
      sec_valid[s] = 1; sec_key[s] = k; sec_count[s] = 0;
      sec_version[s] = 0; sec_dirty[s] = 0;
      res.status = StatAlloc;
    end else begin
      res.status = StatHit;
    end
    idx = s * Cells + lx + ly * SECTION_EDGE + lz * SECTION_EDGE * SECTION_EDGE;
    oid = cell_id.exists(idx) ? cell_id[idx] : '0;
    ocol = cell_color.exists(idx) ? cell_color[idx] : '0;
    res.id = oid;
    res.color = ocol;
    if (kind == KindRead) begin
      res.status = StatHit;
      return res;
    end
    if (oid == nid && ocol == ncol) begin
      res.status = StatUnchanged;
      return res;
    end
    cell_id[idx] = nid;
    cell_color[idx] = (nid == 0) ? '0 : ncol;
    if (oid == 0 && nid != 0) sec_count[s]++;
    if (oid != 0 && nid == 0 && sec_count[s] > 0) sec_count[s]--;
    if (mark) begin
      sec_version[s] = sec_version[s] + 1;
      sec_dirty[s] = 1;
    end
    if (sec_count[s] == 0) begin
      sec_valid[s] = 0;
      sec_dirty[s] = 0;
      res.status = StatFreed;
    end
    return res;
  endfunction

  assign pending_o = result_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    voxel_result_t got, want;
    if (!rst_ni) begin
      errors_o <= 0;
      results_o <= 0;
      result_q.delete();
      cell_id.delete();
      cell_color.delete();
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        sec_valid[i] = 0; sec_count[i] = 0; sec_key[i] = '0;
        sec_version[i] = 0; sec_dirty[i] = 0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_o <= results_o + 1;
        got = '{id: m_axis_tdata[31:0], color: m_axis_tdata[63:32], status: m_axis_tuser};
        if (result_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result %p", got);
          errors_o <= errors_o + 1;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            if (errors_o < 10) $display("mismatch: expected %p, got %p", want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        result_q.insert(result_q.size(), access_voxel(s_axis_tuser, s_axis_tdata));
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives reads and writes into the voxel store: section fills and drains,
// table overflow, coordinate extremes and random traffic under back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import svss_pkg::*;

  localparam int Limit = 200000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  int           errors, pending, results;
  int           idle_cycles = 0;
  bit           calm = 0;
  int           items_sent = 0;

  always #4 clk_i = ~clk_i;

  sparse_voxel_section_store_unit u_top (.*);
  svss_checker u_chk (.*, .errors_o(errors), .pending_o(pending), .results_o(results));

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 8);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Limit) begin
      $display("timeout");
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_voxel(input logic kind, input int x, input int y, input int z,
                            input logic [31:0] id, input logic [31:0] color,
                            input logic mark);
    while (!calm && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, mark, color, id, z[23:0], y[23:0], x[23:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  function automatic int pick_coord(input int base);
    case ($urandom_range(9))
      0: return -8388608;
      1: return 8388607;
      2: return $urandom;
      default: return base * 16 + $urandom_range(15);
    endcase
  endfunction

  initial begin
    int bx, by, bz;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // directed
    send_voxel(KindRead, 0, 0, 0, 0, 0, 0);
    send_voxel(KindWrite, 0, 0, 0, 0, 32'h5, 1);
    send_voxel(KindWrite, -1, -16, -17, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send_voxel(KindRead, -1, -16, -17, 0, 0, 0);
    send_voxel(KindWrite, -1, -16, -17, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send_voxel(KindWrite, -2, -16, -17, 0, 32'h7, 0);
    send_voxel(KindWrite, -8388608, 8388607, -8388608, 1, 2, 0);
    send_voxel(KindWrite, -8388608, 8388607, -8388608, 1, 3, 1);
    send_voxel(KindWrite, -8388608, 8388607, -8388608, 0, 3, 1);
    send_voxel(KindRead, -8388608, 8388607, -8388608, 0, 0, 0);
    for (int i = 0; i < 17; i++) send_voxel(KindWrite, i * 16, 5, 9, i + 1, 32'hA5A5A5A5, 1);
    send_voxel(KindWrite, -1, -16, -17, 0, 0, 1);
    send_voxel(KindWrite, 16 * 16, 5, 9, 9, 9, 0);
    // random: mostly clustered in a few sections so slots fill, hit and free
    for (int n = 0; n < 700; n++) begin
      if (n == 300) calm = 1;
      if (n == 450) calm = 0;
      if (n == 350) drain();
      bx = $urandom_range(20) - 10; by = $urandom_range(3) - 1; bz = $urandom_range(1);
      send_voxel($urandom_range(2) != 0,
                 pick_coord(bx), pick_coord(by), pick_coord(bz),
                 ($urandom_range(2) == 0) ? 0 : ($urandom_range(3) == 0 ? $urandom
                                                   : $urandom_range(3)),
                 ($urandom_range(3) == 0) ? $urandom : $urandom_range(2),
                 $urandom_range(1));
    end
    drain();
    repeat (20) @(posedge clk_i);
    $display("sent %0d items, checked %0d results", items_sent, results);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ----- sparse_voxel_section_store_unit.f -----
rtl/svss_pkg.sv
rtl/svss_coord_split.sv
rtl/sparse_voxel_section_store_unit.sv
verif/svss_checker.sv
verif/tb.sv
